/* rtl/core/bgdm_pkg.sv */
// ----------------------------------------------------------------------------
// bgdm_pkg
// Shared types, constants and tables of the bond graph distance matrix.
// ----------------------------------------------------------------------------
package bgdm_pkg;

   localparam int MAX_ATOMS = 64;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int FRAC_BITS = 10;
   localparam int DIST_W    = 20;
   localparam int ELEM_W    = 7;
   localparam int RAD_W     = 8;
   localparam int BASE_W    = RAD_W + 1;
   localparam int SCALE_W   = 7;

   localparam logic [IDX_W-1:0]  IDX_MAX   = IDX_W'(MAX_ATOMS - 1);
   localparam logic [DIST_W-1:0] DIST_INF  = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAXF = DIST_INF - DIST_W'(1);
   localparam logic [DIST_W-1:0] DIST_ONE  = DIST_W'(1) << FRAC_BITS;

   localparam logic [RAD_W-1:0] RADIUS_DEFAULT = RAD_W'(76);

   localparam logic [SCALE_W-1:0] SCALE_SINGLE   = SCALE_W'(100);
   localparam logic [SCALE_W-1:0] SCALE_DOUBLE   = SCALE_W'(87);
   localparam logic [SCALE_W-1:0] SCALE_TRIPLE   = SCALE_W'(78);
   localparam logic [SCALE_W-1:0] SCALE_AROMATIC = SCALE_W'(92);

   localparam logic [1:0] ORDER_DOUBLE = 2'd2;
   localparam logic [1:0] ORDER_TRIPLE = 2'd3;

   // shared multiplier: plain product or division by reciprocal
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 27;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MUL_Y_W = 26;

   localparam logic [MUL_B_W-1:0] RECIP_10K    = MUL_B_W'(109951163);
   localparam int                 RECIP_10K_SH = 40;
   localparam logic [MUL_B_W-1:0] RECIP_5      = MUL_B_W'(13421773);
   localparam int                 RECIP_5_SH   = 26;
   localparam logic [MUL_A_W-1:0] ROUND_10K    = MUL_A_W'(5000);
   localparam logic [MUL_A_W-1:0] ROUND_5      = MUL_A_W'(2);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_BOND  = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      MUL_PLAIN  = 2'd0,
      MUL_DIV10K = 2'd1,
      MUL_DIV5   = 2'd2
   } mul_op_type;

   typedef struct packed {
      mul_op_type         op;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DIST_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr0;
      logic [ADDR_W-1:0] addr1;
   } ram_rd_type;

   function automatic logic [RAD_W-1:0] radius_of(input logic [ELEM_W-1:0] elem);
      logic [RAD_W-1:0] r;
      case (elem)
         7'd1:    r = RAD_W'(31);
         7'd2:    r = RAD_W'(28);
         7'd3:    r = RAD_W'(128);
         7'd5:    r = RAD_W'(84);
         7'd6:    r = RAD_W'(76);
         7'd7:    r = RAD_W'(71);
         7'd8:    r = RAD_W'(66);
         7'd9:    r = RAD_W'(57);
         7'd10:   r = RAD_W'(58);
         7'd11:   r = RAD_W'(166);
         7'd12:   r = RAD_W'(141);
         7'd13:   r = RAD_W'(121);
         7'd14:   r = RAD_W'(111);
         7'd15:   r = RAD_W'(107);
         7'd16:   r = RAD_W'(105);
         7'd17:   r = RAD_W'(102);
         7'd19:   r = RAD_W'(203);
         7'd20:   r = RAD_W'(176);
         7'd26:   r = RAD_W'(132);
         7'd30:   r = RAD_W'(122);
         7'd33:   r = RAD_W'(119);
         7'd34:   r = RAD_W'(120);
         7'd35:   r = RAD_W'(120);
         7'd53:   r = RAD_W'(139);
         7'd78:   r = RAD_W'(136);
         default: r = RADIUS_DEFAULT;
      endcase
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
                                                 input logic [DIST_W-1:0] y);
      logic [DIST_W:0]   s;
      logic [DIST_W-1:0] r;
      s = {1'b0, x} + {1'b0, y};
      if (x == DIST_INF || y == DIST_INF) begin
         r = DIST_INF;
      end else if (s > {1'b0, DIST_MAXF}) begin
         r = DIST_MAXF;
      end else begin
         r = s[DIST_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/bgdm_if.sv */
// ----------------------------------------------------------------------------
// bgdm_req_if / bgdm_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface bgdm_req_if import bgdm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [IDX_W-1:0]  atom_a;
   logic [IDX_W-1:0]  atom_b;
   logic [ELEM_W-1:0] elem_a;
   logic [ELEM_W-1:0] elem_b;
   logic [1:0]        bond_order;
   logic              aromatic;

   modport source (output valid, req_type, atom_a, atom_b, elem_a, elem_b,
                   bond_order, aromatic, input ready);
   modport sink   (input valid, req_type, atom_a, atom_b, elem_a, elem_b,
                   bond_order, aromatic, output ready);
endinterface

interface bgdm_rsp_if import bgdm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              read_valid;
   logic              index_error;

   modport source (output valid, distance, read_valid, index_error, input ready);
   modport sink   (input valid, distance, read_valid, index_error, output ready);
endinterface

/* rtl/core/bgdm_ram.sv */
// ----------------------------------------------------------------------------
// bgdm_ram
// Distance matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bgdm_ram import bgdm_pkg::*; (
   input  logic              clock,
   input  ram_wr_type        wr,
   input  ram_rd_type        rd,
   output logic [DIST_W-1:0] rd0_data,
   output logic [DIST_W-1:0] rd1_data
);

   logic [DIST_W-1:0] mem [MAX_ATOMS*MAX_ATOMS];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd0_data <= mem[rd.addr0];
      rd1_data <= mem[rd.addr1];
   end

endmodule

/* rtl/core/bgdm_mul.sv */
// ----------------------------------------------------------------------------
// bgdm_mul
// Shared registered multiplier: plain product, or quotient by a constant
// through a reciprocal.
// ----------------------------------------------------------------------------
module bgdm_mul import bgdm_pkg::*; (
   input  logic               clock,
   input  mul_req_type        req,
   output logic [MUL_Y_W-1:0] y
);

   logic [MUL_B_W-1:0] m;
   logic [MUL_P_W-1:0] prod_ff;
   mul_op_type         op_ff;

   always_comb begin
      case (req.op)
         MUL_PLAIN:  m = req.b;
         MUL_DIV10K: m = RECIP_10K;
         MUL_DIV5:   m = RECIP_5;
         default:    m = req.b;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(req.a) * MUL_P_W'(m);
      op_ff   <= req.op;
   end

   always_comb begin
      case (op_ff)
         MUL_PLAIN:  y = prod_ff[MUL_Y_W-1:0];
         MUL_DIV10K: y = MUL_Y_W'(prod_ff >> RECIP_10K_SH);
         MUL_DIV5:   y = MUL_Y_W'(prod_ff >> RECIP_5_SH);
         default:    y = prod_ff[MUL_Y_W-1:0];
      endcase
   end

endmodule

/* rtl/core/bond_graph_distance_matrix.sv */
// ----------------------------------------------------------------------------
// bond_graph_distance_matrix
// All-pairs shortest bond path matrix with bond loads, closure and reads.
// ----------------------------------------------------------------------------
// channel   direction  transaction
// req_chan  in         clear / add bond / run closure and fill / read entry
// rsp_chan  out        one response per request: distance, read flag, error
// csr_*     in         atom_count write, no read-back
//
// The single matrix write port and the one add/compare stage set the run time:
// one relaxation per cycle plus one column fetch per row. No clearing pass
// after reset; the store is undefined until the first clear. A response
// waiting on rsp_chan stalls only the final ST_DONE state of the next request.
// ----------------------------------------------------------------------------
module bond_graph_distance_matrix import bgdm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   bgdm_req_if.sink         req_chan,
   bgdm_rsp_if.source       rsp_chan
);

   typedef enum logic [16:0] {
      ST_IDLE       = 17'h00001,
      ST_CLR        = 17'h00002,
      ST_BOND_MUL   = 17'h00004,
      ST_BOND_DIV   = 17'h00008,
      ST_BOND_WR    = 17'h00010,
      ST_BOND_WR2   = 17'h00020,
      ST_RD         = 17'h00040,
      ST_FW_IK      = 17'h00080,
      ST_FW_ROW     = 17'h00100,
      ST_FW_DRAIN   = 17'h00200,
      ST_SCAN       = 17'h00400,
      ST_SCAN_DRAIN = 17'h00800,
      ST_FILL_MUL   = 17'h01000,
      ST_FILL_DIV   = 17'h02000,
      ST_FILL       = 17'h04000,
      ST_FILL_DRAIN = 17'h08000,
      ST_DONE       = 17'h10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  n_last;
   logic [IDX_W-1:0]  lim;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   req_op_type        op_ff, op_in;
   logic              err_ff, err_in;
   logic [IDX_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [ELEM_W-1:0] ea_ff, ea_in, eb_ff, eb_in;
   logic [1:0]        order_ff, order_in;
   logic              arom_ff, arom_in;
   logic [DIST_W-1:0] cur_ff, cur_in;
   logic [DIST_W-1:0] dik_ff;
   logic [DIST_W-1:0] mx_ff, mx_in;
   logic [DIST_W-1:0] fill_ff, fill_in;
   logic              ik_load_ff, fw_vld_ff, scan_vld_ff, fill_vld_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_read_ff, rsp_read_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              accept;
   logic              bad_idx;
   logic              sweep_end;
   logic [BASE_W-1:0] base;
   logic [SCALE_W-1:0] scale;
   logic [DIST_W-1:0] bond_len;
   logic [DIST_W-1:0] relax_sum;
   logic              is_read;

   ram_wr_type        wr;
   ram_rd_type        rd;
   logic [DIST_W-1:0] rd0_data, rd1_data;
   mul_req_type       mreq;
   logic [MUL_Y_W-1:0] my;

   bgdm_ram u_ram (
      .clock    (clock),
      .wr       (wr),
      .rd       (rd),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   bgdm_mul u_mul (
      .clock (clock),
      .req   (mreq),
      .y     (my)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign accept               = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.distance    = rsp_dist_ff;
   assign rsp_chan.read_valid  = rsp_read_ff;
   assign rsp_chan.index_error = rsp_err_ff;

   assign n_last    = IDX_W'(n_ff - CNT_W'(1));
   assign lim       = (state_ff == ST_CLR) ? IDX_MAX : n_last;
   assign sweep_end = (i_ff == lim) && (j_ff == lim);
   assign bad_idx   = (CNT_W'(req_chan.atom_a) >= n_ff) || (CNT_W'(req_chan.atom_b) >= n_ff);
   assign is_read   = (op_ff == OP_READ);
   assign base      = BASE_W'(radius_of(ea_ff)) + BASE_W'(radius_of(eb_ff));
   assign relax_sum = sat_add(dik_ff, rd0_data);
   assign bond_len  = (my > MUL_Y_W'(DIST_MAXF)) ? DIST_MAXF : my[DIST_W-1:0];

   always_comb begin
      if (arom_ff) begin
         scale = SCALE_AROMATIC;
      end else if (order_ff == ORDER_TRIPLE) begin
         scale = SCALE_TRIPLE;
      end else if (order_ff == ORDER_DOUBLE) begin
         scale = SCALE_DOUBLE;
      end else begin
         scale = SCALE_SINGLE;
      end
   end

   always_comb begin
      if (csr_wr_data == '0) begin
         n_in = CNT_W'(1);
      end else if (csr_wr_data > CNT_W'(MAX_ATOMS)) begin
         n_in = CNT_W'(MAX_ATOMS);
      end else begin
         n_in = csr_wr_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      op_in       = op_ff;
      err_in      = err_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      ea_in       = ea_ff;
      eb_in       = eb_ff;
      order_in    = order_ff;
      arom_in     = arom_ff;
      cur_in      = cur_ff;
      mx_in       = mx_ff;
      fill_in     = fill_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_dist_in = rsp_dist_ff;
      rsp_read_in = rsp_read_ff;
      rsp_err_in  = rsp_err_ff;
      wr          = '0;
      rd.addr0    = {a_ff, b_ff};
      rd.addr1    = {i_ff, j_ff};
      mreq.op     = MUL_PLAIN;
      mreq.a      = MUL_A_W'(base);
      mreq.b      = MUL_B_W'(scale);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op_type'(req_chan.req_type);
               a_in     = req_chan.atom_a;
               b_in     = req_chan.atom_b;
               ea_in    = req_chan.elem_a;
               eb_in    = req_chan.elem_b;
               order_in = req_chan.bond_order;
               arom_in  = req_chan.aromatic;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               err_in   = 1'b0;
               case (req_op_type'(req_chan.req_type))
                  OP_CLEAR: state_in = ST_CLR;
                  OP_BOND: begin
                     err_in   = bad_idx;
                     state_in = bad_idx ? ST_DONE : ST_BOND_MUL;
                  end
                  OP_RUN: begin
                     mx_in    = DIST_ONE;
                     state_in = ST_FW_IK;
                  end
                  OP_READ: begin
                     err_in   = bad_idx;
                     state_in = bad_idx ? ST_DONE : ST_RD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLR: begin
            wr.we   = 1'b1;
            wr.addr = {i_ff, j_ff};
            wr.data = (i_ff == j_ff) ? '0 : DIST_INF;
            if (j_ff == lim) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
            if (sweep_end) begin
               state_in = ST_DONE;
            end
         end
         ST_BOND_MUL: begin
            state_in = ST_BOND_DIV;
         end
         ST_BOND_DIV: begin
            mreq.op  = MUL_DIV10K;
            mreq.a   = (my << FRAC_BITS) + ROUND_10K;
            state_in = ST_BOND_WR;
         end
         ST_BOND_WR: begin
            cur_in   = (bond_len < rd0_data) ? bond_len : rd0_data;
            wr.we    = 1'b1;
            wr.addr  = {a_ff, b_ff};
            wr.data  = cur_in;
            state_in = ST_BOND_WR2;
         end
         ST_BOND_WR2: begin
            wr.we    = 1'b1;
            wr.addr  = {b_ff, a_ff};
            wr.data  = cur_ff;
            state_in = ST_DONE;
         end
         ST_RD: begin
            state_in = ST_DONE;
         end
         ST_FW_IK: begin
            rd.addr0 = {i_ff, k_ff};
            state_in = ST_FW_ROW;
         end
         ST_FW_ROW: begin
            rd.addr0 = {k_ff, j_ff};
            rd.addr1 = {i_ff, j_ff};
            if (j_ff == lim) begin
               j_in     = '0;
               state_in = ST_FW_IK;
               if (i_ff == lim) begin
                  i_in = '0;
                  if (k_ff == lim) begin
                     state_in = ST_FW_DRAIN;
                  end else begin
                     k_in = k_ff + IDX_W'(1);
                  end
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_FW_DRAIN: begin
            state_in = ST_SCAN;
         end
         ST_SCAN, ST_FILL: begin
            rd.addr0 = {i_ff, j_ff};
            if (j_ff == lim) begin
               j_in = '0;
               i_in = (i_ff == lim) ? '0 : i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
            if (sweep_end) begin
               state_in = (state_ff == ST_SCAN) ? ST_SCAN_DRAIN : ST_FILL_DRAIN;
            end
         end
         ST_SCAN_DRAIN: begin
            state_in = ST_FILL_MUL;
         end
         ST_FILL_MUL: begin
            mreq.op  = MUL_DIV5;
            mreq.a   = MUL_A_W'({mx_ff, 3'b000}) + ROUND_5;
            state_in = ST_FILL_DIV;
         end
         ST_FILL_DIV: begin
            fill_in  = bond_len;
            state_in = ST_FILL;
         end
         ST_FILL_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_dist_in = (is_read && !err_ff) ? rd0_data : '0;
               rsp_read_in = is_read;
               rsp_err_in  = err_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // relax, scan and fill stage on registered read data
      if (fw_vld_ff && (relax_sum < rd1_data)) begin
         wr.we   = 1'b1;
         wr.addr = s1_addr_ff;
         wr.data = relax_sum;
      end
      if (scan_vld_ff && (rd0_data != DIST_INF) && (rd0_data > mx_ff)) begin
         mx_in = rd0_data;
      end
      if (fill_vld_ff && (rd0_data == DIST_INF)) begin
         wr.we   = 1'b1;
         wr.addr = s1_addr_ff;
         wr.data = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         n_ff        <= CNT_W'(1);
         mx_ff       <= DIST_ONE;
         rsp_vld_ff  <= 1'b0;
         ik_load_ff  <= 1'b0;
         fw_vld_ff   <= 1'b0;
         scan_vld_ff <= 1'b0;
         fill_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mx_ff       <= mx_in;
         rsp_vld_ff  <= rsp_vld_in;
         ik_load_ff  <= (state_ff == ST_FW_IK);
         fw_vld_ff   <= (state_ff == ST_FW_ROW);
         scan_vld_ff <= (state_ff == ST_SCAN);
         fill_vld_ff <= (state_ff == ST_FILL);
         if (csr_wr_en) begin
            n_ff <= n_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      op_ff       <= op_in;
      err_ff      <= err_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      order_ff    <= order_in;
      arom_ff     <= arom_in;
      cur_ff      <= cur_in;
      fill_ff     <= fill_in;
      s1_addr_ff  <= {i_ff, j_ff};
      rsp_dist_ff <= rsp_dist_in;
      rsp_read_ff <= rsp_read_in;
      rsp_err_ff  <= rsp_err_in;
      if (ik_load_ff) begin
         dik_ff <= rd0_data;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start work");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr.we)
      else $error("matrix written while idle");

   a_error_zero_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_err_ff |-> rsp_dist_ff == '0)
      else $error("index error response carries a distance");

   a_ack_zero_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_read_ff |-> rsp_dist_ff == '0 && !$past(fw_vld_ff && state_ff == ST_IDLE))
      else $error("acknowledge carries a distance");

endmodule
